// ----- hw/rtl/angdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angdc_pkg
// Shared widths, constants and reset values of the noise gate and DC blocker.
// ----------------------------------------------------------------------------
package angdc_pkg;

  // Stream and configuration port widths
  localparam int SAMPLE_W   = 16;
  localparam int TDATA_W    = 16;
  localparam int TUSER_W    = 8;
  localparam int COEF_W     = 16;
  localparam int CHCNT_W    = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_POLE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CHCNT   = 3'd4;

  // Channel interleave
  localparam int MAX_CHANNELS = 2;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W        = 4;

  // Fraction bits of the unsigned Q0.16 coefficients
  localparam int FRAC_W = 16;

  // Serial multiplier: signed multiplicand, unsigned 16-bit multiplier
  localparam int MCAND_W    = 33;
  localparam int MPLIER_W   = 16;
  localparam int PROD_W     = MCAND_W + 1 + MPLIER_W;
  localparam int MUL_STEP_W = $clog2(MPLIER_W);

  // Gate arithmetic: threshold, |x|^2 * a, quotient and root
  localparam int THR_W       = 34;
  localparam int MSQ_W       = 31;
  localparam int P_W         = 46;
  localparam int NUM_W       = P_W + FRAC_W;
  localparam int QUO_W       = 30;
  localparam int DIV_STEP_W  = $clog2(QUO_W);
  localparam int ROOT_W      = QUO_W / 2;
  localparam int SQ_REM_W    = ROOT_W + 2;
  localparam int SQRT_STEP_W = $clog2(ROOT_W);

  // DC blocker
  localparam int YHOLD_W = 18;
  localparam int POLE_W  = 20;
  localparam int SUM_W   = 21;

  localparam logic signed [YHOLD_W-1:0]  YH_MAX  = {1'b0, {(YHOLD_W-1){1'b1}}};
  localparam logic signed [YHOLD_W-1:0]  YH_MIN  = {1'b1, {(YHOLD_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Register reset values
  localparam logic [COEF_W-1:0]  ATTACK_RST  = 16'd66;
  localparam logic [COEF_W-1:0]  RELEASE_RST = 16'd6554;
  localparam logic [COEF_W-1:0]  THRESH_RST  = 16'd655;
  localparam logic [COEF_W-1:0]  POLE_RST    = 16'd65208;
  localparam logic [CHCNT_W-1:0] CHCNT_RST   = 2'd2;

endpackage

// ----- hw/rtl/angdc_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angdc_mul
// Serial-parallel multiplier: one multiplier bit per cycle, signed multiplicand.
// ----------------------------------------------------------------------------
module angdc_mul
  import angdc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [MCAND_W-1:0] mcand_i,
  input  logic [MPLIER_W-1:0]      mplier_i,
  output logic                     done_o,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [MCAND_W-1:0] mcand_q;
  logic [MPLIER_W-1:0]       mplier_q;
  logic [MCAND_W:0]          hi_q;
  logic [MCAND_W:0]          sum;
  logic [MPLIER_W-1:0]       lo_q;
  logic [MUL_STEP_W-1:0]     cnt_q;
  logic                      busy_q;
  logic                      done_q;

  // The partial product stays within the multiplicand range, so one extra bit
  // holds the sum before the arithmetic shift.
  assign sum = hi_q + (mplier_q[0] ? {mcand_q[MCAND_W-1], mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_STEP_W'(MPLIER_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      hi_q     <= '0;
    end else if (busy_q) begin
      hi_q     <= {sum[MCAND_W], sum[MCAND_W:1]};
      lo_q     <= {sum[0], lo_q[MPLIER_W-1:1]};
      mplier_q <= {1'b0, mplier_q[MPLIER_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// ----- hw/rtl/angdc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angdc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module angdc_div
  import angdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [THR_W-1:0]  den_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quo_o
);

  logic [THR_W-1:0]      rem_q;
  logic [THR_W-1:0]      den_q;
  logic [QUO_W-1:0]      bits_q;
  logic [QUO_W-1:0]      quo_q;
  logic [DIV_STEP_W-1:0] cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [THR_W:0]        trial;
  logic [THR_W:0]        diff;
  logic                  ge;

  assign trial = {rem_q, bits_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_STEP_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The caller guarantees that the quotient fits, so the top bits of the
  // dividend already sit below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= THR_W'(num_i[NUM_W-1:QUO_W]);
      bits_q <= num_i[QUO_W-1:0];
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[THR_W-1:0] : trial[THR_W-1:0];
      bits_q <= {bits_q[QUO_W-2:0], 1'b0};
      quo_q  <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- hw/rtl/angdc_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angdc_sqrt
// Digit-by-digit integer square root, one radicand bit pair per cycle.
// ----------------------------------------------------------------------------
module angdc_sqrt
  import angdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QUO_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_REM_W-1:0]    rem_q;
  logic [QUO_W-1:0]       rad_q;
  logic [ROOT_W-1:0]      root_q;
  logic [SQRT_STEP_W-1:0] cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic [SQ_REM_W+1:0]    r4;
  logic [SQ_REM_W+1:0]    trial;
  logic [SQ_REM_W+1:0]    diff;
  logic                   ge;

  assign r4    = {rem_q, rad_q[QUO_W-1:QUO_W-2]};
  assign trial = (SQ_REM_W + 2)'({root_q, 2'b01});
  assign ge    = r4 >= trial;
  assign diff  = r4 - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SQRT_STEP_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The remainder never exceeds twice the partial root, so it fits its width.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      root_q <= '0;
      rad_q  <= rad_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[SQ_REM_W-1:0] : r4[SQ_REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
      rad_q  <= {rad_q[QUO_W-3:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- hw/rtl/adaptive_noise_gate_dc_block.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_noise_gate_dc_block
// An ungated sample passes the envelope and threshold products of the
// 16-step serial multiplier; a gated one also passes two more products,
// the 30-step divider and the 15-step square root.
// Throughput: one word at a time; the next word is accepted the cycle after
// the result enters the output register. Reset clears all control and per-channel state at once.
// ----------------------------------------------------------------------------
module adaptive_noise_gate_dc_block
  import angdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [15:0] sample_in
  input  logic                  s_axis_tlast,   // frame_end
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [15:0] sample_out
  output logic [TUSER_W-1:0]    m_axis_tuser,   // [0] channel_out, [1] clipped, rest zero
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_ENV, ST_THR, ST_MSQ, ST_MA, ST_DIV, ST_SQRT, ST_FIN
  } state_e;

  state_e state_q;

  // Configuration
  logic [COEF_W-1:0]  attack_q, release_q, thresh_q, pole_q;
  logic [CHCNT_W-1:0] chcnt_q;

  // Per-channel state
  logic [SAMPLE_W-1:0]        env_q   [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] gprev_q [MAX_CHANNELS];
  logic signed [YHOLD_W-1:0]  yprev_q [MAX_CHANNELS];
  logic [CH_W-1:0]            pos_q;

  // Current word
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       last_q;
  logic [CH_W-1:0]            ch_q;
  logic [SAMPLE_W-1:0]        mag_q;
  logic [SAMPLE_W-1:0]        a_q;
  logic                       up_q;
  logic [THR_W-1:0]           thr_q;
  logic signed [SAMPLE_W-1:0] g_q;
  logic                       pole_rdy_q;

  // Unit control
  logic                      m0_start_q, m1_start_q, div_start_q, sqrt_start_q;
  logic signed [MCAND_W-1:0] m0_a_q, m1_a_q;
  logic [MPLIER_W-1:0]       m0_b_q, m1_b_q;
  logic                      m0_done, m1_done, div_done, sqrt_done;
  logic signed [PROD_W-1:0]  m0_prod, m1_prod;
  logic [QUO_W-1:0]          quo;
  logic [ROOT_W-1:0]         root;

  // Output register
  logic                       m_valid_q;
  logic signed [SAMPLE_W-1:0] m_data_q;
  logic                       m_ch_q;
  logic                       m_clip_q;

  // Combinational datapath
  logic [SAMPLE_W-1:0]        in_mag, in_a;
  logic [SAMPLE_W-1:0]        env_cur, d, env_new;
  logic                       up;
  logic [SAMPLE_W:0]          inc;
  logic [THR_W-1:0]           thr_sum;
  logic                       gated;
  logic [SAMPLE_W-1:0]        root_ext;
  logic signed [SAMPLE_W-1:0] g_root;
  logic signed [POLE_W-1:0]   pole_term;
  logic signed [SUM_W-1:0]    y_sum;
  logic signed [YHOLD_W-1:0]  y_hold;
  logic signed [SAMPLE_W-1:0] y_out;
  logic                       clip;
  logic [CNT_W-1:0]           eff_cnt, ch_inc;
  logic [CH_W-1:0]            pos_next;

  // Magnitude in Q0.16; the most negative sample saturates to full scale.
  assign in_mag = s_axis_tdata[SAMPLE_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
  assign in_a   = in_mag[SAMPLE_W-1] ? '1 : {in_mag[SAMPLE_W-2:0], 1'b0};

  assign env_cur = env_q[ch_q];
  assign up      = a_q > env_cur;
  assign d       = up ? (a_q - env_cur) : (env_cur - a_q);

  // Rounded envelope step; it never exceeds the distance to the magnitude.
  assign inc     = {1'b0, m0_prod[2*FRAC_W-1:FRAC_W]} + (SAMPLE_W + 1)'(m0_prod[FRAC_W-1]);
  assign env_new = up_q ? (env_cur + inc[SAMPLE_W-1:0]) : (env_cur - inc[SAMPLE_W-1:0]);

  assign thr_sum = {2'b00, thresh_q, {FRAC_W{1'b0}}} + {2'b00, m0_prod[2*FRAC_W-1:0]};
  assign gated   = {2'b00, a_q, {FRAC_W{1'b0}}} < thr_sum;

  assign root_ext = SAMPLE_W'(root);
  assign g_root   = x_q[SAMPLE_W-1] ? (~root_ext + 1'b1) : root_ext;

  // Pole product rounded to the nearest, halves toward plus infinity.
  assign pole_term = m1_prod[POLE_W+FRAC_W-1:FRAC_W] + POLE_W'(m1_prod[FRAC_W-1]);
  assign y_sum     = SUM_W'(g_q) - SUM_W'(gprev_q[ch_q]) + SUM_W'(pole_term);

  always_comb begin
    if (y_sum > SUM_W'(YH_MAX)) begin
      y_hold = YH_MAX;
    end else if (y_sum < SUM_W'(YH_MIN)) begin
      y_hold = YH_MIN;
    end else begin
      y_hold = y_sum[YHOLD_W-1:0];
    end
    if (y_hold > YHOLD_W'(OUT_MAX)) begin
      y_out = OUT_MAX;
      clip  = 1'b1;
    end else if (y_hold < YHOLD_W'(OUT_MIN)) begin
      y_out = OUT_MIN;
      clip  = 1'b1;
    end else begin
      y_out = y_hold[SAMPLE_W-1:0];
      clip  = 1'b0;
    end
  end

  // A zero count acts as one channel, a count above the maximum saturates.
  always_comb begin
    if (chcnt_q == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (CNT_W'(chcnt_q) > CNT_W'(MAX_CHANNELS)) begin
      eff_cnt = CNT_W'(MAX_CHANNELS);
    end else begin
      eff_cnt = CNT_W'(chcnt_q);
    end
    ch_inc   = CNT_W'(ch_q) + 1'b1;
    pos_next = (last_q || ch_inc >= eff_cnt) ? '0 : ch_inc[CH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RST;
      release_q <= RELEASE_RST;
      thresh_q  <= THRESH_RST;
      pole_q    <= POLE_RST;
      chcnt_q   <= CHCNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ATTACK:  attack_q  <= cfg_data_i;
        REG_RELEASE: release_q <= cfg_data_i;
        REG_THRESH:  thresh_q  <= cfg_data_i;
        REG_POLE:    pole_q    <= cfg_data_i;
        REG_CHCNT:   chcnt_q   <= cfg_data_i[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        env_q[i]   <= '0;
        gprev_q[i] <= '0;
        yprev_q[i] <= '0;
      end
      x_q          <= '0;
      last_q       <= 1'b0;
      ch_q         <= '0;
      mag_q        <= '0;
      a_q          <= '0;
      up_q         <= 1'b0;
      thr_q        <= '0;
      g_q          <= '0;
      pole_rdy_q   <= 1'b0;
      m0_start_q   <= 1'b0;
      m1_start_q   <= 1'b0;
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      m0_a_q       <= '0;
      m0_b_q       <= '0;
      m1_a_q       <= '0;
      m1_b_q       <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      m_ch_q       <= 1'b0;
      m_clip_q     <= 1'b0;
    end else begin
      m0_start_q   <= 1'b0;
      m1_start_q   <= 1'b0;
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      if (m1_done) begin
        pole_rdy_q <= 1'b1;
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            x_q     <= s_axis_tdata;
            last_q  <= s_axis_tlast;
            ch_q    <= pos_q;
            mag_q   <= in_mag;
            a_q     <= in_a;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // The pole product runs on its own unit alongside the gate.
          up_q       <= up;
          m0_a_q     <= MCAND_W'(d);
          m0_b_q     <= up ? attack_q : release_q;
          m0_start_q <= 1'b1;
          m1_a_q     <= MCAND_W'(yprev_q[ch_q]);
          m1_b_q     <= pole_q;
          m1_start_q <= 1'b1;
          pole_rdy_q <= 1'b0;
          state_q    <= ST_ENV;
        end
        ST_ENV: begin
          if (m0_done) begin
            env_q[ch_q] <= env_new;
            m0_a_q      <= MCAND_W'(env_new);
            m0_b_q      <= thresh_q;
            m0_start_q  <= 1'b1;
            state_q     <= ST_THR;
          end
        end
        ST_THR: begin
          if (m0_done) begin
            thr_q <= thr_sum;
            if (gated) begin
              m0_a_q     <= MCAND_W'(mag_q);
              m0_b_q     <= mag_q;
              m0_start_q <= 1'b1;
              state_q    <= ST_MSQ;
            end else begin
              g_q     <= x_q;
              state_q <= ST_FIN;
            end
          end
        end
        ST_MSQ: begin
          if (m0_done) begin
            m0_a_q     <= MCAND_W'(m0_prod[MSQ_W-1:0]);
            m0_b_q     <= a_q;
            m0_start_q <= 1'b1;
            state_q    <= ST_MA;
          end
        end
        ST_MA: begin
          if (m0_done) begin
            div_start_q <= 1'b1;
            state_q     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            sqrt_start_q <= 1'b1;
            state_q      <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            g_q     <= g_root;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (pole_rdy_q && (!m_valid_q || m_axis_tready)) begin
            m_valid_q     <= 1'b1;
            m_data_q      <= y_out;
            m_ch_q        <= ch_q[0];
            m_clip_q      <= clip;
            gprev_q[ch_q] <= g_q;
            yprev_q[ch_q] <= y_hold;
            pos_q         <= pos_next;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  angdc_mul u_mul_gate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (m0_start_q),
    .mcand_i  (m0_a_q),
    .mplier_i (m0_b_q),
    .done_o   (m0_done),
    .prod_o   (m0_prod)
  );

  angdc_mul u_mul_pole (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (m1_start_q),
    .mcand_i  (m1_a_q),
    .mplier_i (m1_b_q),
    .done_o   (m1_done),
    .prod_o   (m1_prod)
  );

  // The dividend is |x|^2 * a scaled by 2^16; the product stays in the
  // gate multiplier until the divider has loaded it.
  angdc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   ({m0_prod[P_W-1:0], {FRAC_W{1'b0}}}),
    .den_i   (thr_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  angdc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_q),
    .rad_i   (quo),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = {{(TUSER_W-2){1'b0}}, m_clip_q, m_ch_q};

endmodule

// ----- hw/rtl/angdc_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angdc_chk
// Port-level checks of the noise gate and DC blocker, bound to the top level.
// ----------------------------------------------------------------------------
module angdc_chk
  import angdc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [TUSER_W-1:0] m_axis_tuser
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Words are processed one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in progress");

  // No result can follow an accepted word in the very next cycle.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared without processing time");

  // A clipped result sits on one of the two rails.
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata == TDATA_W'(OUT_MAX) || m_axis_tdata == TDATA_W'(OUT_MIN)))
    else $error("clipped flag on an unsaturated sample");

endmodule

bind adaptive_noise_gate_dc_block angdc_chk u_angdc_chk (.*);

// ----- tb/tb_adaptive_noise_gate_dc_block.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_noise_gate_dc_block
// Self-checking bench for the noise gate and DC blocker. A driver process
// feeds PCM words from a queue and predicts each gated, filtered output in
// place. A monitor compares every output word with the oldest prediction.
// Register settings change between phases, from the extremes to random values.
// ----------------------------------------------------------------------------
module tb_adaptive_noise_gate_dc_block;
  import angdc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASE_WORDS = 205;
  localparam int LONG_HOLD   = 400;

  typedef enum int { MODE_QUIET, MODE_NEAR, MODE_LOUD, MODE_EDGE, MODE_FULL } stim_mode_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
    logic                drain_first;
  } pcm_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                chan;
    logic                clip;
  } gated_out_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;  // [15:0] sample_in
  logic                  s_axis_tlast  = 1'b0; // frame_end
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;        // [15:0] sample_out
  logic [TUSER_W-1:0]    m_axis_tuser;        // [0] channel_out, [1] clipped, rest zero
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Predictor copy of the registers and the per-channel state
  logic [COEF_W-1:0]         attack_q  = ATTACK_RST;
  logic [COEF_W-1:0]         release_q = RELEASE_RST;
  logic [COEF_W-1:0]         thresh_q  = THRESH_RST;
  logic [COEF_W-1:0]         pole_q    = POLE_RST;
  logic [CHCNT_W-1:0]        chcnt_q   = CHCNT_RST;
  logic [15:0]               env_q  [MAX_CHANNELS];
  logic signed [15:0]        gin_q  [MAX_CHANNELS];
  logic signed [YHOLD_W-1:0] yout_q [MAX_CHANNELS];
  int unsigned               chan_pos = 0;

  pcm_word_t  pending_samples[$];
  gated_out_t expected_outputs[$];
  pcm_word_t  cur_word;

  logic idle_on = 1'b1;
  int   send_gap = 0;
  int   recv_hold = 0;
  int   stall_cycles = 0;
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   words_sent = 0;
  int   gated_count = 0;
  int   clipped_count = 0;
  int   settings_done = 0;

  adaptive_noise_gate_dc_block i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Advances the predictor by one word and returns the output word it causes.
  function automatic gated_out_t gate_filter_sample(input pcm_word_t w);
    int                x;
    int unsigned       cnt, ch, mag, a, env;
    longint unsigned   thr, m2, root;
    longint            g, pole_term, y, y_sat;
    gated_out_t        r;
    cnt = chcnt_q;
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_CHANNELS) cnt = MAX_CHANNELS;
    ch = chan_pos;
    if (ch >= MAX_CHANNELS) ch = 0;

    x   = $signed(w.sample);
    mag = (x < 0) ? -x : x;
    a   = 2 * mag;
    if (a > 65535) a = 65535;

    // The envelope moves toward the magnitude by a rounded fraction of the gap.
    env = env_q[ch];
    if (a > env) env = env + int'((64'(attack_q) * 64'(a - env) + 64'd32768) >> 16);
    else env = env - int'((64'(release_q) * 64'(env - a) + 64'd32768) >> 16);
    env_q[ch] = 16'(env);

    thr = 64'(thresh_q) * (64'd65536 + 64'(env_q[ch]));
    g   = x;
    if (64'(a) * 64'd65536 < thr) begin
      m2   = (64'(mag) * 64'(mag) * 64'(a) * 64'd65536) / thr;
      root = int_sqrt(m2);
      g    = (x < 0) ? -longint'(root) : longint'(root);
      gated_count++;
    end

    pole_term = (longint'(pole_q) * longint'(yout_q[ch]) + 32768) >>> 16;
    y = g - longint'(gin_q[ch]) + pole_term;
    if (y > 131071) y = 131071;
    if (y < -131072) y = -131072;
    gin_q[ch]  = 16'(g);
    yout_q[ch] = YHOLD_W'(y);

    y_sat = y;
    if (y_sat > 32767) y_sat = 32767;
    if (y_sat < -32768) y_sat = -32768;
    r.sample = 16'(y_sat);
    r.chan   = ch[0];
    r.clip   = (y_sat != y);
    if (r.clip) clipped_count++;

    if (w.frame_end || ch + 1 >= cnt) chan_pos = 0;
    else chan_pos = ch + 1;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic int make_sample(input stim_mode_e mode);
    int mag;
    case (mode)
      MODE_QUIET: mag = $urandom_range(0, 600);
      MODE_NEAR:  mag = $urandom_range(0, int'(thresh_q) / 2 + 256);
      MODE_LOUD:  mag = $urandom_range(16384, 32768);
      MODE_EDGE: begin
        case ($urandom_range(0, 3))
          0:       mag = 32768;
          1:       mag = 32767;
          2:       mag = 0;
          default: mag = 1;
        endcase
      end
      default: return int'($signed(16'($urandom)));
    endcase
    if (mag > 32768) mag = 32768;
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100)
      $display("mismatch in %s at output %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    mismatch_count++;
  endtask

  task automatic push_word(input int value, input bit last, input bit drain);
    pcm_word_t w;
    w.sample      = 16'(value);
    w.frame_end   = last;
    w.drain_first = drain;
    pending_samples.push_back(w);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_ATTACK:  attack_q  = value;
      REG_RELEASE: release_q = value;
      REG_THRESH:  thresh_q  = value;
      REG_POLE:    pole_q    = value;
      REG_CHCNT:   chcnt_q   = value[CHCNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(input int atk, input int rel, input int thr, input int pole,
                               input int cnt);
    write_reg(REG_ATTACK, CFG_DATA_W'(atk));
    write_reg(REG_RELEASE, CFG_DATA_W'(rel));
    write_reg(REG_THRESH, CFG_DATA_W'(thr));
    write_reg(REG_POLE, CFG_DATA_W'(pole));
    write_reg(REG_CHCNT, CFG_DATA_W'(cnt));
    settings_done++;
  endtask

  // Block is idle once nothing waits to be sent, nothing is on the bus and
  // every predicted output has been seen.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0);
  endtask

  // Bursts of one kind of material, so the envelope gets to settle and swing.
  task automatic run_phase(input int n_words, input logic idle);
    int         run_left;
    stim_mode_e mode;
    @(negedge clk_i);
    idle_on  = idle;
    run_left = 0;
    mode     = MODE_FULL;
    for (int i = 0; i < n_words; i++) begin
      if (run_left == 0) begin
        mode     = stim_mode_e'($urandom_range(0, 4));
        run_left = $urandom_range(4, 40);
      end
      run_left--;
      push_word(make_sample(mode), $urandom_range(0, 9) == 0, $urandom_range(0, 149) == 0);
    end
    wait_drained();
  endtask

  initial begin : stimulus
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      env_q[c]  = '0;
      gin_q[c]  = '0;
      yout_q[c] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words at the reset settings: magnitudes around the gate,
    // full-scale swings that saturate, the most negative sample and frame ends.
    push_word(0, 0, 0);
    push_word(32767, 0, 0);
    push_word(-32768, 0, 0);
    push_word(32767, 0, 0);
    push_word(-32768, 0, 0);
    push_word(-32767, 0, 0);
    push_word(1, 0, 0);
    push_word(-1, 0, 0);
    push_word(100, 0, 0);
    push_word(-100, 0, 0);
    push_word(300, 0, 0);
    push_word(-300, 0, 0);
    push_word(327, 1, 0);
    push_word(328, 1, 0);
    push_word(-20, 0, 1);
    push_word(20, 0, 0);
    push_word(16384, 0, 0);
    push_word(-16384, 1, 0);
    push_word(5, 0, 0);
    push_word(-5, 0, 0);
    push_word(32767, 0, 1);
    push_word(0, 0, 0);
    push_word(0, 0, 0);
    push_word(0, 1, 0);
    wait_drained();

    run_phase(PHASE_WORDS, 1'b0);

    // Leave the interleave on channel 1 so that the drop to one channel
    // below has to wrap at once.
    if (chan_pos == 0) begin
      push_word(make_sample(MODE_FULL), 0, 0);
      wait_drained();
    end

    apply_setting(65535, 65535, 65535, 65535, 1);
    run_phase(PHASE_WORDS, 1'b1);

    // Zero threshold gates nothing; a zero count means one channel.
    apply_setting(0, 0, 0, 0, 0);
    run_phase(PHASE_WORDS, 1'b1);

    // A count above the channel limit saturates to it.
    apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 4000), $urandom_range(0, 65535), 3);
    run_phase(PHASE_WORDS, 1'b1);

    // Writes to unused indexes must leave every register as it is.
    apply_setting(1000, 200, 0, 65535, 2);
    for (int i = int'(REG_CHCNT) + 1; i < (1 << CFG_ADDR_W); i++)
      write_reg(CFG_ADDR_W'(i), CFG_DATA_W'($urandom));
    run_phase(PHASE_WORDS, 1'b1);

    for (int p = 0; p < 3; p++) begin
      apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 1) ? $urandom_range(0, 4000) : $urandom_range(0, 65535),
                    $urandom_range(0, 1) ? $urandom_range(60000, 65535) : $urandom_range(0, 65535),
                    $urandom_range(0, 3));
      run_phase(PHASE_WORDS, 1'b1);
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_outputs.size() != 0)
      report_mismatch("outputs still expected", 0, expected_outputs.size());

    $display("Summary: %0d samples over %0d register settings, %0d of them gated,",
             words_sent, settings_done + 1, gated_count);
    $display("         %0d outputs saturated, %0d outputs checked, %0d mismatches.",
             clipped_count, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk_i) begin : sample_driver
    logic offer;
    if (rst_ni) begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outputs.push_back(gate_filter_sample(cur_word));
        words_sent++;
        offer    = 1'b0;
        send_gap = pick_gap();
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() > 0 &&
                     (!pending_samples[0].drain_first || expected_outputs.size() == 0)) begin
          cur_word = pending_samples.pop_front();
          s_axis_tdata <= cur_word.sample;
          s_axis_tlast <= cur_word.frame_end;
          offer = 1'b1;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    gated_out_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch("unexpected output word", $signed(m_axis_tdata), 0);
        end else begin
          want = expected_outputs.pop_front();
          if (m_axis_tdata !== want.sample)
            report_mismatch("sample_out", $signed(m_axis_tdata), $signed(want.sample));
          if (m_axis_tuser[0] !== want.chan)
            report_mismatch("channel_out", m_axis_tuser[0], want.chan);
          if (m_axis_tuser[1] !== want.clip)
            report_mismatch("clipped", m_axis_tuser[1], want.clip);
          if (m_axis_tuser[TUSER_W-1:2] !== '0)
            report_mismatch("unused tuser bits", m_axis_tuser, 0);
        end
        results_seen++;
        // Now and then hold off long enough that the block backs up into its input.
        if (results_seen % 500 == 250) recv_hold = LONG_HOLD;
        else recv_hold = pick_gap();
      end else if (m_axis_tready && recv_hold == 0 && idle_on && $urandom_range(0, 15) == 0) begin
        recv_hold = pick_gap();
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
